/* rtl/lzss_stream_decoder_macros.svh */
// Assertion macros for the decoder RTL.
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define LSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/lsd_pkg.sv */
package lsd_pkg;

    localparam int RING_SIZE_DEF      = 4096;
    localparam int MAX_MATCH_DEF      = 18;
    localparam int MIN_MATCH_BIAS_DEF = 2;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int LEN_W  = 5;
    localparam int FLAG_W = 9;

    localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic load_flags;
        logic lit;
        logic store_low;
        logic start_match;
        logic copy_step;
        logic preset;
    } t_cmd;

    typedef struct packed {
        logic pend;
        logic adv;
        logic copy_final;
        logic flag_empty;
        logic flag_bit;
        logic match_phase;
    } t_status;

endpackage

/* rtl/lzss_stream_decoder.sv */
// LZSS decoder with a 4096-byte history ring: one compressed byte is taken per input
// word and decompressed bytes leave one per output word, tlast marking the final byte
// caused by an input word. A flag byte or a match's first byte does not stall input;
// a literal holds off the next word until it is in the ring, a match until its last
// byte is, since the single read port of the ring memory yields one copied byte per
// cycle while the output is taken. After an input word with tlast, a drain state
// precedes the next word, in which the ring returns to its preset contents; a fill
// count stands in for the preset, so no clearing pass is needed.
`include "lzss_stream_decoder_macros.svh"

module lzss_stream_decoder
    import lsd_pkg::*;
    #(
        parameter int RING_SIZE      = RING_SIZE_DEF,
        parameter int MAX_MATCH      = MAX_MATCH_DEF,
        parameter int MIN_MATCH_BIAS = MIN_MATCH_BIAS_DEF
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  logic              i_s_tvalid,
        output logic              o_s_tready,
        input  logic [BYTE_W-1:0] i_s_tdata,   // in_byte
        input  logic              i_s_tlast,   // stream_end
        output logic              o_m_tvalid,
        input  logic              i_m_tready,
        output logic [BYTE_W-1:0] o_m_tdata,   // out_byte
        output logic              o_m_tlast    // run_last
    );

    t_cmd    cmd;
    t_status status;

    lsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_end   (i_s_tlast),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lsd_datapath #(
        .RING_SIZE      (RING_SIZE),
        .MAX_MATCH      (MAX_MATCH),
        .MIN_MATCH_BIAS (MIN_MATCH_BIAS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_byte   (i_s_tdata),
        .o_status    (status),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_byte  (o_m_tdata),
        .o_run_last  (o_m_tlast)
    );

    `LSD_ASSERT_IMP(a_no_accept_pend, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !status.pend)
    `LSD_ASSERT_NXT(a_end_blocks, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready)
    `LSD_ASSERT_NXT(a_pend_held, i_clk, i_rst_n, status.pend && !status.adv, status.pend)

endmodule

/* rtl/lsd_ram.sv */
module lsd_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 4096
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic                     i_re,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lsd_datapath.sv */
module lsd_datapath
    import lsd_pkg::*;
    #(
        parameter int RING_SIZE      = RING_SIZE_DEF,
        parameter int MAX_MATCH      = MAX_MATCH_DEF,
        parameter int MIN_MATCH_BIAS = MIN_MATCH_BIAS_DEF
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  t_cmd              i_cmd,
        input  logic [BYTE_W-1:0] i_in_byte,
        output t_status           o_status,
        output logic              o_out_valid,
        input  logic              i_out_ready,
        output logic [BYTE_W-1:0] o_out_byte,
        output logic              o_run_last
    );

    localparam int AW         = $clog2(RING_SIZE);
    localparam int PRESET_POS = RING_SIZE - MAX_MATCH;
    localparam logic [AW-1:0]   PRESET_A = AW'(PRESET_POS);
    localparam logic [AW:0]     FULL_CNT = (AW + 1)'(RING_SIZE);
    localparam logic [LEN_W-1:0] LEN_ADD = LEN_W'(MIN_MATCH_BIAS + 1);

    logic [AW-1:0]     r_wpos, r_rd_ptr;
    logic [AW:0]       r_cnt;
    logic [FLAG_W-1:0] r_flag;
    logic              r_phase;
    logic [BYTE_W-1:0] r_low;
    logic [LEN_W-1:0]  r_remain;
    logic              r_pend, r_pend_last, r_lit_src;
    logic [BYTE_W-1:0] r_lit;
    logic              r_fwd, r_written;
    logic [BYTE_W-1:0] r_fwd_data, r_preset_byte;
    logic              r_oval, r_olast;
    logic [BYTE_W-1:0] r_obyte;

    logic              adv, issue, we;
    logic [BYTE_W-1:0] sel, ram_q;
    logic [POS_W-1:0]  match_pos;
    logic [AW-1:0]     rd_off;

    assign adv       = !r_oval || i_out_ready;
    assign issue     = i_cmd.copy_step && adv;
    assign we        = r_pend && adv;
    assign match_pos = {i_in_byte[7:4], r_low};
    assign rd_off    = r_rd_ptr - PRESET_A;

    always_comb begin
        if (r_lit_src) begin
            sel = r_lit;
        end else if (r_fwd) begin
            sel = r_fwd_data;
        end else if (r_written) begin
            sel = ram_q;
        end else begin
            sel = r_preset_byte;
        end
    end

    lsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wpos),
        .i_wdata (sel),
        .i_re    (issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= PRESET_A;
            r_cnt       <= '0;
            r_flag      <= '0;
            r_phase     <= 1'b0;
            r_low       <= '0;
            r_remain    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_lit_src   <= 1'b0;
            r_oval      <= 1'b0;
        end else begin
            if (we) begin
                r_wpos <= r_wpos + 1'b1;
                if (r_cnt != FULL_CNT) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (adv) begin
                r_oval <= r_pend;
            end
            if (i_cmd.lit) begin
                r_pend      <= 1'b1;
                r_pend_last <= 1'b1;
                r_lit_src   <= 1'b1;
            end else if (adv) begin
                r_pend <= issue;
                if (issue) begin
                    r_pend_last <= (r_remain == LEN_W'(1));
                    r_lit_src   <= 1'b0;
                end
            end
            if (i_cmd.load_flags) begin
                r_flag  <= {1'b1, i_in_byte};
                r_phase <= 1'b0;
            end
            if (i_cmd.lit) begin
                r_flag <= r_flag >> 1;
            end
            if (i_cmd.store_low) begin
                r_low   <= i_in_byte;
                r_phase <= 1'b1;
            end
            if (i_cmd.start_match) begin
                r_rd_ptr <= match_pos[AW-1:0];
                r_remain <= LEN_W'(i_in_byte[3:0]) + LEN_ADD;
                r_flag   <= r_flag >> 1;
                r_phase  <= 1'b0;
            end
            if (issue) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_remain <= r_remain - 1'b1;
            end
            if (i_cmd.preset) begin
                r_wpos  <= PRESET_A;
                r_cnt   <= '0;
                r_flag  <= '0;
                r_phase <= 1'b0;
                r_low   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lit) begin
            r_lit <= i_in_byte;
        end
        if (issue) begin
            r_fwd         <= we && (r_rd_ptr == r_wpos);
            r_fwd_data    <= sel;
            r_written     <= ({1'b0, rd_off} < r_cnt);
            r_preset_byte <= (r_rd_ptr < PRESET_A) ? SPACE_BYTE : '0;
        end
        if (adv && r_pend) begin
            r_obyte <= sel;
            r_olast <= r_pend_last;
        end
    end

    assign o_status.pend        = r_pend;
    assign o_status.adv         = adv;
    assign o_status.copy_final  = (r_remain == LEN_W'(1));
    assign o_status.flag_empty  = (r_flag[FLAG_W-1:1] == '0);
    assign o_status.flag_bit    = r_flag[0];
    assign o_status.match_phase = r_phase;

    assign o_out_valid = r_oval;
    assign o_out_byte  = r_obyte;
    assign o_run_last  = r_olast;

endmodule

/* rtl/lsd_ctrl.sv */
module lsd_ctrl
    import lsd_pkg::*;
    (
        input  logic    i_clk,
        input  logic    i_rst_n,
        input  logic    i_in_valid,
        input  logic    i_in_end,
        output logic    o_in_ready,
        input  t_status i_status,
        output t_cmd    o_cmd
    );

    t_state r_state, n_state;
    logic   r_end, n_end;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_status.pend;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_end = i_in_end;
                    if (i_status.match_phase) begin
                        o_cmd.start_match = 1'b1;
                        n_state = S_COPY;
                    end else begin
                        if (i_status.flag_empty) begin
                            o_cmd.load_flags = 1'b1;
                        end else if (i_status.flag_bit) begin
                            o_cmd.lit = 1'b1;
                        end else begin
                            o_cmd.store_low = 1'b1;
                        end
                        if (i_in_end) begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.adv && i_status.copy_final) begin
                    n_state = r_end ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (!i_status.pend) begin
                    o_cmd.preset = 1'b1;
                    n_end   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* sim/lzss_stream_decoder_tb.sv */
`timescale 1ns / 1ps

module lzss_stream_decoder_tb
    import lsd_pkg::*;
    ();

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_WORDS   = 100;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [POS_W-1:0] START_POS = POS_W'(RING_SIZE_DEF - MAX_MATCH_DEF);

    typedef enum logic {
        PH_TOKEN,
        PH_MATCH_HI
    } t_phase;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              hold;
    } t_in_word;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_word;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic [BYTE_W-1:0] i_s_tdata  = '0;
    logic              i_s_tlast  = 1'b0;
    logic              i_m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [BYTE_W-1:0] o_m_tdata;
    logic              o_m_tlast;

    lzss_stream_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // in_byte
        .i_s_tlast  (i_s_tlast),   // stream_end
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // out_byte
        .o_m_tlast  (o_m_tlast)    // run_last
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_in_word  pend_words[$];
    t_out_word decoded_q[$];

    logic [BYTE_W-1:0] hist_mem [RING_SIZE_DEF];
    logic [POS_W-1:0]  wr_ptr;
    logic [FLAG_W-1:0] flag_sr;
    t_phase            tok_phase;
    logic [BYTE_W-1:0] match_lo;

    logic [POS_W-1:0]  gen_wr;
    int                n_words;
    int                mismatch_cnt;
    int                idle_cnt;
    bit                s_taken;

    task automatic preset_history();
        for (int i = 0; i < RING_SIZE_DEF; i++) begin
            hist_mem[i] = (i < RING_SIZE_DEF - MAX_MATCH_DEF) ? SPACE_BYTE : '0;
        end
        wr_ptr    = START_POS;
        flag_sr   = '0;
        tok_phase = PH_TOKEN;
        match_lo  = '0;
    endtask

    task automatic emit_byte(input logic [BYTE_W-1:0] c);
        decoded_q.push_back('{data: c, last: 1'b0});
        hist_mem[wr_ptr] = c;
        wr_ptr = wr_ptr + 1'b1;
    endtask

    task automatic decode_word(input logic [BYTE_W-1:0] b, input logic stream_end);
        int               first;
        int unsigned      run_len;
        logic [POS_W-1:0] src;
        t_out_word        tail;
        first = decoded_q.size();
        if (tok_phase == PH_MATCH_HI) begin
            src     = {b[7:4], match_lo};
            run_len = b[3:0] + MIN_MATCH_BIAS_DEF + 1;
            for (int unsigned k = 0; k < run_len; k++) begin
                emit_byte(hist_mem[src + POS_W'(k)]);
            end
            flag_sr   = flag_sr >> 1;
            tok_phase = PH_TOKEN;
        end else begin
            tok_phase = PH_TOKEN;
            if (flag_sr <= 1) begin
                flag_sr = {1'b1, b};
            end else if (flag_sr[0]) begin
                emit_byte(b);
                flag_sr = flag_sr >> 1;
            end else begin
                match_lo  = b;
                tok_phase = PH_MATCH_HI;
            end
        end
        if (decoded_q.size() > first) begin
            tail      = decoded_q.pop_back();
            tail.last = 1'b1;
            decoded_q.push_back(tail);
        end
        if (stream_end) begin
            preset_history();
        end
    endtask

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic last, input logic hold);
        pend_words.push_back('{data: b, last: last, hold: hold});
        n_words++;
    endtask

    task automatic gen_stream(input bit broken, input bit hold);
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] flags;
        logic [POS_W-1:0]  pos;
        logic [3:0]        len_code;
        int                cut;
        bit                ended;
        for (int g = $urandom_range(1, 2); g > 0; g--) begin
            flags = BYTE_W'($urandom);
            body.push_back(flags);
            for (int t = 0; t < 8; t++) begin
                if (flags[t]) begin
                    body.push_back(BYTE_W'($urandom));
                    gen_wr = gen_wr + 1'b1;
                end else begin
                    case ($urandom_range(0, 4))
                        0:       pos = POS_W'($urandom);
                        1:       pos = gen_wr;
                        default: pos = gen_wr - POS_W'($urandom_range(1, 24));
                    endcase
                    len_code = 4'($urandom);
                    body.push_back(pos[7:0]);
                    body.push_back({pos[11:8], len_code});
                    gen_wr = gen_wr + POS_W'(len_code + MIN_MATCH_BIAS_DEF + 1);
                end
            end
        end
        cut   = broken ? $urandom_range(1, body.size() - 1) : body.size();
        ended = broken || ($urandom_range(0, 3) != 0);
        for (int i = 0; i < cut; i++) begin
            push_word(body[i], ended && (i == cut - 1), hold && (i == 0));
        end
        if (ended) begin
            gen_wr = START_POS;
        end
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            push_word(BYTE_W'($urandom), i == n - 1, 1'b0);
        end
        gen_wr = START_POS;
    endtask

    task automatic fill_directed();
        push_word(8'h05, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hEE, 1'b0, 1'b0);
        push_word(8'hF0, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'h0F, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h10, 1'b1, 1'b0);
        push_word(8'hA7, 1'b1, 1'b0);
        push_word(8'hFF, 1'b0, 1'b1);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hFF, 1'b0, 1'b0);
        push_word(8'h55, 1'b0, 1'b0);
        push_word(8'hAA, 1'b0, 1'b0);
        push_word(8'h01, 1'b0, 1'b0);
        push_word(8'h80, 1'b0, 1'b0);
        push_word(8'h7F, 1'b0, 1'b0);
        push_word(8'hFE, 1'b0, 1'b0);
        push_word(8'h00, 1'b0, 1'b0);
        push_word(8'hF4, 1'b0, 1'b0);
        push_word(8'hFF, 1'b1, 1'b0);
        gen_wr = START_POS;
    endtask

    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_in_word w;
        logic     vld;
        logic [BYTE_W-1:0] dat;
        logic     lst;
        vld = i_s_tvalid;
        dat = i_s_tdata;
        lst = i_s_tlast;
        if (i_rst_n) begin
            if (vld && s_taken) begin
                vld = 1'b0;
            end
            if (!vld) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_words.size() > 0 &&
                             !(pend_words[0].hold && decoded_q.size() > 0)) begin
                    w   = pend_words.pop_front();
                    vld = 1'b1;
                    dat = w.data;
                    lst = w.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        i_s_tvalid <= vld;
        i_s_tdata  <= dat;
        i_s_tlast  <= lst;
    end

    int rx_mode  = 0;
    int rx_left  = 0;
    int rx_stall = 0;

    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 80);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 7) != 0);
            default: begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    rdy = 1'b0;
                end else begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 5) == 0) begin
                        rx_stall = $urandom_range(5, 20);
                    end
                end
            end
        endcase
        i_m_tready <= rdy;
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        s_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (s_taken) begin
                decode_word(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected word out_byte=%h run_last=%b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    exp_w = decoded_q.pop_front();
                    if (o_m_tdata !== exp_w.data) begin
                        mismatch_cnt++;
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp_w.data, o_m_tdata);
                    end
                    if (o_m_tlast !== exp_w.last) begin
                        mismatch_cnt++;
                        $display("%0t: run_last expected %b actual %b",
                                 $time, exp_w.last, o_m_tlast);
                    end
                end
            end
            if (s_taken || (o_m_tvalid && i_m_tready)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int target;
        int r;
        mismatch_cnt = 0;
        idle_cnt     = 0;
        n_words      = 0;
        preset_history();
        fill_directed();
        target = n_words + RANDOM_WORDS;
        while (n_words < target) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                gen_stream(1'b0, $urandom_range(0, 14) == 0);
            end else if (r < 8) begin
                gen_stream(1'b1, 1'b0);
            end else begin
                gen_noise();
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pend_words.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
